// ===== design/assert_macros.svh =====
// Shared assertion macros for the sample decoder checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/asw_pkg.sv =====
`default_nettype none
package asw_pkg;

	localparam int CFG_DATA_W  = 5;
	localparam int CFG_INDEX_W = 2;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_FORMAT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LITTLE_ENDIAN = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_COMPRESSION   = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd3;

	// sample formats
	localparam logic [2:0] FMT_INT8    = 3'd0;
	localparam logic [2:0] FMT_INT16   = 3'd1;
	localparam logic [2:0] FMT_INT24   = 3'd2;
	localparam logic [2:0] FMT_INT32   = 3'd3;
	localparam logic [2:0] FMT_INT64   = 3'd4;
	localparam logic [2:0] FMT_FLOAT32 = 3'd5;
	localparam logic [2:0] FMT_FLOAT64 = 3'd6;

	// compression codes
	localparam logic [1:0] CMP_PCM   = 2'd0;
	localparam logic [1:0] CMP_MULAW = 2'd1;
	localparam logic [1:0] CMP_ALAW  = 2'd2;

	// G.711 constants
	localparam logic [7:0]  ALAW_XOR   = 8'h55;
	localparam logic [15:0] MU_OFFSET  = 16'h0084;
	localparam logic [15:0] ALAW_BIAS  = 16'h0108;

	localparam int CH_HARD_LIMIT = 16;

	typedef struct packed {
		logic [2:0] sample_format;
		logic       little_endian;
		logic [1:0] compression;
		logic [4:0] channel_count;
	} cfg_t;

	typedef struct packed {
		logic        ok;
		logic        is_float;
		logic [63:0] value;
	} dec_res_t;

endpackage
`default_nettype wire

// ===== design/asw_decode.sv =====
`default_nettype none
module asw_decode
	import asw_pkg::*;
(
	input  var cfg_t        cfg,
	input  wire  [63:0]     raw,
	output var dec_res_t    res
);

	function automatic logic [63:0] bswap64(input logic [63:0] w);
		logic [63:0] r;
		for (int i = 0; i < 8; i++) begin
			r[8*i +: 8] = w[8*(7-i) +: 8];
		end
		return r;
	endfunction

	logic [7:0]  mu_u;
	logic [15:0] mu_t;
	logic [16:0] mu_lin;
	logic [7:0]  al_a;
	logic [2:0]  al_seg;
	logic [15:0] al_base;
	logic [15:0] al_mag;
	logic [16:0] al_lin;
	logic [63:0] be64;
	logic [63:0] pcm;

	always_comb begin
		mu_u   = ~raw[7:0];
		mu_t   = (16'({mu_u[3:0], 3'b000}) + MU_OFFSET) << mu_u[6:4];
		mu_lin = mu_u[7] ? ({1'b0, MU_OFFSET} - {1'b0, mu_t})
			: ({1'b0, mu_t} - {1'b0, MU_OFFSET});

		al_a    = raw[7:0] ^ ALAW_XOR;
		al_seg  = al_a[6:4];
		al_base = 16'({al_a[3:0], 4'b0000});
		if (al_seg == 3'd0) begin
			al_mag = al_base + 16'd8;
		end else begin
			al_mag = (al_base + ALAW_BIAS) << (al_seg - 3'd1);
		end
		al_lin = al_a[7] ? {1'b0, al_mag} : (17'd0 - {1'b0, al_mag});
	end

	always_comb begin
		be64 = bswap64(raw);
		res  = '0;
		pcm  = '0;
		unique case (cfg.compression)
			CMP_MULAW: begin
				res.ok    = 1'b1;
				res.value = {{47{mu_lin[16]}}, mu_lin};
			end
			CMP_ALAW: begin
				res.ok    = 1'b1;
				res.value = {{47{al_lin[16]}}, al_lin};
			end
			CMP_PCM: begin
				res.ok = 1'b1;
				unique case (cfg.sample_format)
					FMT_INT8: begin
						res.value = {{56{raw[7]}}, raw[7:0]};
					end
					FMT_INT16: begin
						pcm[15:0] = cfg.little_endian ? raw[15:0] : be64[63:48];
						res.value = {{48{pcm[15]}}, pcm[15:0]};
					end
					FMT_INT24: begin
						pcm[23:0] = cfg.little_endian ? raw[23:0] : be64[63:40];
						res.value = {{40{pcm[23]}}, pcm[23:0]};
					end
					FMT_INT32: begin
						pcm[31:0] = cfg.little_endian ? raw[31:0] : be64[63:32];
						res.value = {{32{pcm[31]}}, pcm[31:0]};
					end
					FMT_INT64: begin
						res.value = cfg.little_endian ? raw : be64;
					end
					FMT_FLOAT32: begin
						res.is_float = 1'b1;
						res.value    = {32'd0,
							(cfg.little_endian ? raw[31:0] : be64[63:32])};
					end
					FMT_FLOAT64: begin
						res.is_float = 1'b1;
						res.value    = cfg.little_endian ? raw : be64;
					end
					default: begin
						res.ok = 1'b0;
					end
				endcase
			end
			default: begin
				res.ok = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== design/audio_sample_word_decoder.sv =====
// Audio sample word decoder: turns the raw bytes of one interleaved sample
// (first stored byte in bits 7:0) into a sign-extended 64-bit linear value for
// 8/16/24/32/64-bit PCM in either byte order, or a 16-bit linear value for
// G.711 mu-law and A-law bytes; float formats come out as byte-ordered raw bits
// with float_bits set. Each result carries its channel index and a frame_last
// mark from a channel counter. One sample is taken every clock while in_stall
// is low; an accepted sample is held in the input register and the decode
// logic feeds the result register, which presents the result. While a
// result is held by out_stall one more sample can wait in the input register;
// the input stalls only when both registers are full.
// Samples under an invalid format/compression selection produce no result and
// leave the channel counter alone. The user must write configuration only while
// no beat is in flight; the block itself does not enforce this.
`default_nettype none
module audio_sample_word_decoder
	import asw_pkg::*;
#(
	parameter int MAX_CHANNELS = 16
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_we,
	input  wire  [CFG_INDEX_W-1:0] cfg_index,
	input  wire  [CFG_DATA_W-1:0]  cfg_data,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire  [63:0]            sample_bytes,
	output logic                   out_valid,
	input  wire                    out_stall,
	output logic signed [63:0]     sample_value,
	output logic                   float_bits,
	output logic [3:0]             channel_index,
	output logic                   frame_last
);

	localparam int CH_LIMIT =
		(MAX_CHANNELS < CH_HARD_LIMIT) ? MAX_CHANNELS : CH_HARD_LIMIT;

	cfg_t        cfg_q;
	logic [3:0]  chan_cnt_q;
	logic        valid_s1;
	logic [63:0] bytes_s1;
	logic        valid_s2;
	logic [63:0] value_s2;
	logic        float_s2;
	logic [3:0]  chan_s2;
	logic        last_s2;
	dec_res_t    dec;
	logic        adv;
	logic [4:0]  count_eff;
	logic        last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_format <= FMT_INT16;
			cfg_q.little_endian <= 1'b0;
			cfg_q.compression   <= CMP_PCM;
			cfg_q.channel_count <= 5'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SAMPLE_FORMAT: cfg_q.sample_format <= cfg_data[2:0];
				REG_LITTLE_ENDIAN: cfg_q.little_endian <= cfg_data[0];
				REG_COMPRESSION:   cfg_q.compression   <= cfg_data[1:0];
				REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[4:0];
			endcase
		end
	end

	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			bytes_s1 <= sample_bytes;
		end
	end

	asw_decode u_decode (
		.cfg (cfg_q),
		.raw (bytes_s1),
		.res (dec)
	);

	always_comb begin
		count_eff = cfg_q.channel_count;
		if (count_eff == 5'd0) begin
			count_eff = 5'd1;
		end
		if (count_eff > 5'(CH_LIMIT)) begin
			count_eff = 5'(CH_LIMIT);
		end
		last = ({1'b0, chan_cnt_q} + 5'd1) >= count_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			chan_cnt_q <= '0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && dec.ok;
			if (valid_s1 && dec.ok) begin
				chan_cnt_q <= last ? 4'd0 : chan_cnt_q + 4'd1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv && valid_s1 && dec.ok) begin
			value_s2 <= dec.value;
			float_s2 <= dec.is_float;
			chan_s2  <= chan_cnt_q;
			last_s2  <= last;
		end
	end

	assign out_valid     = valid_s2;
	assign sample_value  = value_s2;
	assign float_bits    = float_s2;
	assign channel_index = chan_s2;
	assign frame_last    = last_s2;

endmodule
`default_nettype wire

// ===== design/asw_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module asw_checker
	import asw_pkg::*;
(
	input wire               clk,
	input wire               arst_n,
	input wire               in_stall,
	input wire               out_valid,
	input wire               out_stall,
	input wire signed [63:0] sample_value,
	input wire        [3:0]  channel_index,
	input wire               frame_last
);

	logic [3:0] exp_idx_q;

	// channel expected on the next delivered beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (out_valid && !out_stall) begin
			exp_idx_q <= frame_last ? 4'd0 : channel_index + 4'd1;
		end
	end

	`ASW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample_value), "stalled result beat changed")
	`ASW_ASSERT_NOW(a_chan_seq, out_valid, channel_index == exp_idx_q, "channel index out of sequence")
	`ASW_ASSERT_NOW(a_last_top, out_valid && channel_index == 4'd15, frame_last, "top channel not marked last")
	`ASW_ASSERT_NOW(a_no_idle_stall, !out_valid, !in_stall, "input stalled with empty output")

endmodule

bind audio_sample_word_decoder asw_checker u_asw_checker (.*);
`default_nettype wire

// ===== tb/audio_sample_word_decoder_test.sv =====
`default_nettype none
module audio_sample_word_decoder_test;
	import asw_pkg::*;

	localparam int CHANNEL_CAP = 16;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_SAMPLES = 1700;
	localparam int REPORT_LIMIT = 10;
	localparam logic [2:0] FMT_INVALID = 3'd7;
	localparam logic [1:0] CMP_INVALID = 2'd3;

	typedef struct {
		logic [63:0] value;
		logic        is_float;
		logic [3:0]  chan;
		logic        last;
	} decoded_sample_t;

	class decode_scoreboard;
		logic [2:0] fmt;
		logic       le;
		logic [1:0] cmp;
		logic [4:0] chans;
		logic [3:0] chan_ctr;
		decoded_sample_t expected_samples[$];
		int errors;

		function new();
			fmt = FMT_INT16;
			le = 1'b0;
			cmp = CMP_PCM;
			chans = 5'd2;
			chan_ctr = 4'd0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_SAMPLE_FORMAT: fmt = d[2:0];
				REG_LITTLE_ENDIAN: le = d[0];
				REG_COMPRESSION: cmp = d[1:0];
				REG_CHANNEL_COUNT: chans = d[4:0];
				default: ;
			endcase
		endfunction

		function logic [63:0] byte_order(logic [63:0] raw, int n);
			logic [63:0] v;
			v = '0;
			for (int i = 0; i < n; i++) begin
				if (le)
					v[8*i +: 8] = raw[8*i +: 8];
				else
					v[8*(n-1-i) +: 8] = raw[8*i +: 8];
			end
			return v;
		endfunction

		function logic [63:0] mulaw_linear(logic [7:0] b);
			logic [7:0]  u;
			logic [63:0] t;
			u = ~b;
			t = ({57'd0, u[3:0], 3'd0} + 64'(MU_OFFSET)) << u[6:4];
			return u[7] ? 64'(MU_OFFSET) - t : t - 64'(MU_OFFSET);
		endfunction

		function logic [63:0] alaw_linear(logic [7:0] b);
			logic [7:0]  a;
			logic [2:0]  seg;
			logic [63:0] mag;
			a = b ^ ALAW_XOR;
			seg = a[6:4];
			mag = {56'd0, a[3:0], 4'd0};
			if (seg == 3'd0)
				mag = mag + 64'd8;
			else
				mag = (mag + 64'(ALAW_BIAS)) << (seg - 1);
			return a[7] ? mag : -mag;
		endfunction

		function void note_sample(logic [63:0] raw);
			decoded_sample_t r;
			logic [63:0] g;
			bit ok;
			int n;
			ok = 1'b1;
			r.is_float = 1'b0;
			r.value = '0;
			case (cmp)
				CMP_MULAW: r.value = mulaw_linear(raw[7:0]);
				CMP_ALAW: r.value = alaw_linear(raw[7:0]);
				CMP_PCM: begin
					case (fmt)
						FMT_INT8: r.value = {{56{raw[7]}}, raw[7:0]};
						FMT_INT16: begin
							g = byte_order(raw, 2);
							r.value = {{48{g[15]}}, g[15:0]};
						end
						FMT_INT24: begin
							g = byte_order(raw, 3);
							r.value = {{40{g[23]}}, g[23:0]};
						end
						FMT_INT32: begin
							g = byte_order(raw, 4);
							r.value = {{32{g[31]}}, g[31:0]};
						end
						FMT_INT64: r.value = byte_order(raw, 8);
						FMT_FLOAT32: begin
							r.value = byte_order(raw, 4);
							r.is_float = 1'b1;
						end
						FMT_FLOAT64: begin
							r.value = byte_order(raw, 8);
							r.is_float = 1'b1;
						end
						default: ok = 1'b0;
					endcase
				end
				default: ok = 1'b0;
			endcase
			if (!ok)
				return;
			n = (chans == 0) ? 1 : (chans > 16) ? 16 : int'(chans);
			if (n > CHANNEL_CAP)
				n = CHANNEL_CAP;
			r.chan = chan_ctr;
			r.last = (int'(chan_ctr) + 1 >= n);
			chan_ctr = r.last ? 4'd0 : chan_ctr + 4'd1;
			expected_samples.push_back(r);
		endfunction

		function void check_result(logic [63:0] value, logic is_float, logic [3:0] chan,
				logic last);
			decoded_sample_t e;
			if (expected_samples.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("unexpected result beat: value %h channel %0d", value, chan);
				return;
			end
			e = expected_samples.pop_front();
			if (value !== e.value || is_float !== e.is_float || chan !== e.chan
					|| last !== e.last) begin
				errors++;
				if (errors <= REPORT_LIMIT) begin
					$display("mismatch: value exp %h got %h, float exp %b got %b",
						e.value, value, e.is_float, is_float);
					$display("          channel exp %0d got %0d, last exp %b got %b",
						e.chan, chan, e.last, last);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [63:0] sample_bytes;
	logic out_valid;
	logic out_stall;
	logic signed [63:0] sample_value;
	logic float_bits;
	logic [3:0] channel_index;
	logic frame_last;

	decode_scoreboard sb = new();
	int send_idle_pct;
	int stall_pct;
	int quiet_cycles;
	int valid_sent;

	audio_sample_word_decoder #(
		.MAX_CHANNELS(CHANNEL_CAP)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_bytes(sample_bytes),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_value(sample_value),
		.float_bits(float_bits),
		.channel_index(channel_index),
		.frame_last(frame_last)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_sample(sample_bytes);
			if (out_valid && !out_stall)
				sb.check_result(sample_value, float_bits, channel_index, frame_last);
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_beat(logic [63:0] raw);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_bytes <= raw;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_samples.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		sb.set_reg(idx, d);
	endtask

	task automatic configure(logic [2:0] f, logic l, logic [1:0] c, logic [4:0] n);
		settle();
		write_reg(REG_SAMPLE_FORMAT, CFG_DATA_W'(f));
		write_reg(REG_LITTLE_ENDIAN, CFG_DATA_W'(l));
		write_reg(REG_COMPRESSION, CFG_DATA_W'(c));
		write_reg(REG_CHANNEL_COUNT, n);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [63:0] random_word();
		logic [63:0] w;
		case ($urandom_range(9))
			0: w = '1;
			1: w = '0;
			2: w = 64'h80 << (8 * $urandom_range(7));
			3: w = ~(64'h80 << (8 * $urandom_range(7)));
			default: w = {$urandom, $urandom};
		endcase
		return w;
	endfunction

	task automatic random_phase();
		logic [2:0] f;
		logic [1:0] c;
		logic [4:0] n;
		int r;
		int items;
		bit dead;
		f = ($urandom_range(11) == 0) ? FMT_INVALID : 3'($urandom_range(6));
		r = $urandom_range(99);
		c = (r < 70) ? CMP_PCM : (r < 82) ? CMP_MULAW : (r < 94) ? CMP_ALAW : CMP_INVALID;
		case ($urandom_range(7))
			0: n = 5'd0;
			1: n = 5'd1;
			2: n = 5'd16;
			3: n = 5'($urandom_range(17, 31));
			default: n = 5'($urandom_range(1, 16));
		endcase
		configure(f, 1'($urandom), c, n);
		dead = (c == CMP_INVALID) || (c == CMP_PCM && f == FMT_INVALID);
		items = dead ? 5 : $urandom_range(20, 80);
		case ($urandom_range(3))
			0: begin send_idle_pct = 0; stall_pct = 0; end
			1: begin send_idle_pct = 76; stall_pct = 0; end
			2: begin send_idle_pct = 0; stall_pct = 76; end
			default: begin send_idle_pct = 24; stall_pct = 24; end
		endcase
		for (int i = 0; i < items; i++)
			send_beat(random_word());
		if (!dead)
			valid_sent += items;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		sample_bytes = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		valid_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: int16 big endian, two channels
		send_beat(64'h0000_0000_0000_0080);
		send_beat(64'hFFFF_FFFF_FFFF_FF7F);
		send_beat('1);
		configure(FMT_INT8, 1'b1, CMP_PCM, 5'd1);
		send_beat(64'h0000_0000_0000_0080);
		send_beat(64'hFFFF_FFFF_FFFF_FF7F);
		configure(FMT_INT24, 1'b1, CMP_PCM, 5'd16);
		send_beat(64'hFFFF_FFFF_FF80_0000);
		send_beat(64'h0000_0000_007F_FFFF);
		send_beat(64'h0000_0000_0000_0001);
		// lowering the count below the counter ends the frame at once
		configure(FMT_INT32, 1'b0, CMP_PCM, 5'd0);
		send_beat(64'h0000_0000_0000_0080);
		send_beat(64'hFFFF_FFFF_FFFF_FF7F);
		configure(FMT_INT64, 1'b1, CMP_PCM, 5'd17);
		send_beat(64'h8000_0000_0000_0000);
		send_beat(64'h7FFF_FFFF_FFFF_FFFF);
		configure(FMT_FLOAT32, 1'b0, CMP_PCM, 5'd31);
		send_beat(64'h1234_5678_BF80_0000);
		configure(FMT_FLOAT64, 1'b1, CMP_PCM, 5'd3);
		send_beat(64'hFFF0_0000_0000_0001);
		configure(FMT_INVALID, 1'b0, CMP_PCM, 5'd3);
		send_beat(64'h0000_0000_0000_1234);
		configure(FMT_INVALID, 1'b1, CMP_MULAW, 5'd3);
		send_beat(64'hFFFF_FFFF_FFFF_FF00);
		send_beat(64'h0000_0000_0000_00FF);
		send_beat(64'h0000_0000_0000_007F);
		send_beat(64'h0000_0000_0000_0080);
		configure(FMT_INT64, 1'b0, CMP_ALAW, 5'd3);
		send_beat(64'h0000_0000_0000_0055);
		send_beat(64'h0000_0000_0000_00D5);
		send_beat(64'hFFFF_FFFF_FFFF_FF00);
		send_beat(64'h0000_0000_0000_0080);
		configure(FMT_INT16, 1'b0, CMP_INVALID, 5'd2);
		send_beat(64'h0000_0000_0000_5555);

		while (valid_sent < RANDOM_SAMPLES)
			random_phase();

		settle();
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire
